// ----- sv/elg_pkg.sv -----
`default_nettype none
package elg_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int CNT_W      = $clog2(WORD_WIDTH);
  localparam int ADDR_W     = 4;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam cnt_t CNT_LAST = CNT_W'(WORD_WIDTH - 1);

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_MODULUS    = 2'd0,
    REG_GENERATOR  = 2'd1,
    REG_PUBLIC_KEY = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_G,
    ST_RED_K,
    ST_RED_M,
    ST_SQ1,
    ST_SQ2,
    ST_MUL1,
    ST_MUL2,
    ST_FIN,
    ST_DONE
  } state_t;

  // modular multiplier request / response
  typedef struct packed {
    logic  go;
    word_t a;
    word_t b;
    word_t p;
  } mm_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } mm_rsp_t;

endpackage
`default_nettype wire

// ----- sv/elg_mulmod.sv -----
`default_nettype none
// Bit-serial interleaved modular multiplier: a * b mod p, a < p, p >= 2.
// One multiplier bit per cycle, MSB first.
module elg_mulmod import elg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  logic  running;
  logic  done_r;
  cnt_t  cnt;
  word_t a_r;
  word_t b_r;
  word_t p_r;
  word_t acc;

  logic [WORD_WIDTH:0] dbl;
  logic [WORD_WIDTH:0] dred;
  logic [WORD_WIDTH:0] sum;
  logic [WORD_WIDTH:0] sred;
  logic [WORD_WIDTH:0] p_ext;

  always_comb begin
    p_ext = {1'b0, p_r};
    dbl   = {acc, 1'b0};
    dred  = (dbl >= p_ext) ? dbl - p_ext : dbl;
    sum   = dred + (b_r[WORD_WIDTH-1] ? {1'b0, a_r} : '0);
    sred  = (sum >= p_ext) ? sum - p_ext : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done_r  <= 1'b0;
      cnt     <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go && !running) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          running <= 1'b0;
          done_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go && !running) begin
      a_r <= req.a;
      b_r <= req.b;
      p_r <= req.p;
      acc <= '0;
    end else if (running) begin
      acc <= sred[WORD_WIDTH-1:0];
      b_r <= {b_r[WORD_WIDTH-2:0], 1'b0};
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc;

endmodule
`default_nettype wire

// ----- sv/elg_cfg.sv -----
`default_nettype none
// APB register file: modulus, generator, public key.
module elg_cfg import elg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output word_t             modulus,
  output word_t             generator,
  output word_t             public_key
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= WORD_WIDTH'(2147483647);
      generator  <= WORD_WIDTH'(2);
      public_key <= WORD_WIDTH'(1);
    end else if (wr_en) begin
      case (idx)
        REG_MODULUS:    modulus    <= pwdata[WORD_WIDTH-1:0];
        REG_GENERATOR:  generator  <= pwdata[WORD_WIDTH-1:0];
        REG_PUBLIC_KEY: public_key <= pwdata[WORD_WIDTH-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODULUS:    prdata = 32'(modulus);
      REG_GENERATOR:  prdata = 32'(generator);
      REG_PUBLIC_KEY: prdata = 32'(public_key);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/elgamal_encrypt_block_core.sv -----
`default_nettype none
// ElGamal encryption core: cipher_first = g^e mod p, cipher_second = m * k^e mod p.
// The arithmetic takes (68 + 2 * popcount(e)) modular products, run one after another;
// one request at a time, busy high throughout.
// A modulus of 0 or 1 bypasses the arithmetic: both results are zero.
// A new request waits until done (one bit-serial multiplier); done is never stalled.
// rst is synchronous, active high: sequencer idle, configuration registers back to defaults.
module elgamal_encrypt_block_core import elg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // request
  input  logic              start,
  output logic              busy,
  input  word_t             message_block,
  input  word_t             ephemeral_exponent,
  // result
  output logic              done,
  output word_t             cipher_first,
  output word_t             cipher_second
);

  word_t   modulus;
  word_t   generator;
  word_t   public_key;

  state_t  state;
  state_t  state_next;
  logic    issued;
  logic    zero;
  word_t   mb;     // message, reduced mod p after ST_RED_M
  word_t   gb;     // generator mod p
  word_t   kb;     // public key mod p
  word_t   r1;     // running power of g
  word_t   r2;     // running power of k, then final product
  word_t   e_sh;   // exponent, MSB first
  cnt_t    bit_cnt;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic    accept;
  logic    op_state;
  logic    adv;
  logic    last_bit;

  elg_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .modulus    (modulus),
    .generator  (generator),
    .public_key (public_key)
  );

  elg_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign done     = (state == ST_DONE);
  assign last_bit = (bit_cnt == CNT_LAST);

  // exponent bit finished: after squaring with a zero bit, or after both multiplies
  assign adv = mm_rsp.done &&
               (((state == ST_SQ2) && !e_sh[WORD_WIDTH-1]) || (state == ST_MUL2));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (mm_req.go) begin
        issued <= 1'b1;
      end else if (mm_rsp.done) begin
        issued <= 1'b0;
      end
    end
  end

  // next state and multiplier operand selection
  always_comb begin
    state_next = state;
    op_state   = 1'b1;
    mm_req.a   = WORD_WIDTH'(1);
    mm_req.b   = generator;
    mm_req.p   = modulus;
    case (state)
      ST_IDLE: begin
        op_state = 1'b0;
        if (start) begin
          // modulus 0 or 1: every result is zero
          state_next = (modulus <= WORD_WIDTH'(1)) ? ST_DONE : ST_RED_G;
        end
      end
      ST_RED_G: begin
        if (mm_rsp.done) state_next = ST_RED_K;
      end
      ST_RED_K: begin
        mm_req.b = public_key;
        if (mm_rsp.done) state_next = ST_RED_M;
      end
      ST_RED_M: begin
        mm_req.b = mb;
        if (mm_rsp.done) state_next = ST_SQ1;
      end
      ST_SQ1: begin
        mm_req.a = r1;
        mm_req.b = r1;
        if (mm_rsp.done) state_next = ST_SQ2;
      end
      ST_SQ2: begin
        mm_req.a = r2;
        mm_req.b = r2;
        if (mm_rsp.done) begin
          if (e_sh[WORD_WIDTH-1]) state_next = ST_MUL1;
          else                    state_next = last_bit ? ST_FIN : ST_SQ1;
        end
      end
      ST_MUL1: begin
        mm_req.a = gb;
        mm_req.b = r1;
        if (mm_rsp.done) state_next = ST_MUL2;
      end
      ST_MUL2: begin
        mm_req.a = kb;
        mm_req.b = r2;
        if (mm_rsp.done) state_next = last_bit ? ST_FIN : ST_SQ1;
      end
      ST_FIN: begin
        mm_req.a = mb;
        mm_req.b = r2;
        if (mm_rsp.done) state_next = ST_DONE;
      end
      ST_DONE: begin
        op_state   = 1'b0;
        state_next = ST_IDLE;
      end
      default: begin
        op_state   = 1'b0;
        state_next = ST_IDLE;
      end
    endcase
    mm_req.go = op_state && !issued;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mb      <= message_block;
      e_sh    <= ephemeral_exponent;
      bit_cnt <= '0;
      r1      <= WORD_WIDTH'(1);
      r2      <= WORD_WIDTH'(1);
      zero    <= (modulus <= WORD_WIDTH'(1));
    end else begin
      if (mm_rsp.done) begin
        case (state)
          ST_RED_G:          gb <= mm_rsp.result;
          ST_RED_K:          kb <= mm_rsp.result;
          ST_RED_M:          mb <= mm_rsp.result;
          ST_SQ1, ST_MUL1:   r1 <= mm_rsp.result;
          ST_SQ2, ST_MUL2,
          ST_FIN:            r2 <= mm_rsp.result;
          default:           ;
        endcase
      end
      if (adv) begin
        e_sh    <= {e_sh[WORD_WIDTH-2:0], 1'b0};
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
  end

  assign cipher_first  = zero ? '0 : r1;
  assign cipher_second = zero ? '0 : r2;

endmodule
`default_nettype wire

// ----- bench/elgamal_encrypt_block_core_test.sv -----
`default_nettype none
module elgamal_encrypt_block_core_test;
  import elg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // idle cycles tolerated: slowest request plus the longest sender gap,
  // with headroom
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // cycles left after the last ciphertext for any stray strobe to show up
  localparam int unsigned TAIL_CYCLES    = 50;
  // a register slot the core does not implement; writes to it must be ignored
  localparam logic [1:0]  REG_UNUSED     = 2'd3;

  // Holds a copy of the key registers, works out the ciphertext for every
  // accepted request and checks the core's results against it in order.
  class cipher_tracker;
    typedef struct {
      word_t first;
      word_t second;
    } cipher_t;

    word_t       modulus;
    word_t       generator;
    word_t       public_key;
    cipher_t     pending_ciphers[$];
    int unsigned fail_count;

    function new();
      modulus    = 32'd2147483647;
      generator  = 32'd2;
      public_key = 32'd1;
      fail_count = 0;
    endfunction

    function void set_reg(reg_idx_t idx, word_t value);
      case (idx)
        REG_MODULUS:    modulus    = value;
        REG_GENERATOR:  generator  = value;
        REG_PUBLIC_KEY: public_key = value;
        default:        ;
      endcase
    endfunction

    // exact modular product: operands below 2^32, so 64 bits never overflow
    function word_t product_mod(word_t x, word_t y, word_t p);
      bit [63:0] wide_x;
      bit [63:0] wide_y;
      bit [63:0] wide_p;
      wide_x = x;
      wide_y = y;
      wide_p = p;
      return word_t'((wide_x * wide_y) % wide_p);
    endfunction

    // left-to-right square-and-multiply over every exponent bit, p > 0
    function word_t power_mod(word_t base, word_t e, word_t p);
      word_t acc;
      word_t reduced;
      acc     = 32'd1 % p;
      reduced = base % p;
      for (int b = WORD_WIDTH - 1; b >= 0; b--) begin
        acc = product_mod(acc, acc, p);
        if (e[b])
          acc = product_mod(acc, reduced, p);
      end
      return acc;
    endfunction

    function void note_request(word_t m, word_t e);
      cipher_t c;
      c.first  = '0;
      c.second = '0;
      // modulus of zero: nothing defined, both halves come back as zero
      if (modulus != 0) begin
        c.first  = power_mod(generator, e, modulus);
        c.second = product_mod(m % modulus, power_mod(public_key, e, modulus), modulus);
      end
      pending_ciphers.insert(pending_ciphers.size(), c);
    endfunction

    function void check_result(word_t first, word_t second);
      cipher_t c;
      if (pending_ciphers.size() == 0) begin
        $error("unexpected ciphertext: cipher_first %h cipher_second %h", first, second);
        fail_count++;
        return;
      end
      c = pending_ciphers.pop_front();
      if (first !== c.first) begin
        $error("cipher_first: expected %h, actual %h", c.first, first);
        fail_count++;
      end
      if (second !== c.second) begin
        $error("cipher_second: expected %h, actual %h", c.second, second);
        fail_count++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  word_t             message_block = '0;
  word_t             ephemeral_exponent = '0;
  logic              done;
  word_t             cipher_first;
  word_t             cipher_second;

  cipher_tracker tracker = new();
  int unsigned   idle_cycles = 0;
  int unsigned   burst_left = 0;

  elgamal_encrypt_block_core dut (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .start              (start),
    .busy               (busy),
    .message_block      (message_block),
    .ephemeral_exponent (ephemeral_exponent),
    .done               (done),
    .cipher_first       (cipher_first),
    .cipher_second      (cipher_second)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: done marks a single-cycle ciphertext, nothing can stall it.
  always @(posedge clk) begin
    if (!rst && done)
      tracker.check_result(cipher_first, cipher_second);
  end

  // Watchdog: any accepted request, result or register write restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // All tasks below are entered just after a rising edge and return just after one.

  // Present a request and hold it until the core takes it (start high, busy low).
  // start is left high so that a following request in the same burst goes back to back.
  task automatic send_request(word_t m, word_t e);
    start              <= 1'b1;
    message_block      <= m;
    ephemeral_exponent <= e;
    do @(posedge clk); while (busy);
    tracker.note_request(m, e);
  endtask

  // Drop start and wait until every ciphertext is in and the core is idle again.
  task automatic wait_idle();
    start <= 1'b0;
    while (tracker.pending_ciphers.size() != 0 || busy)
      @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle held until pready.
  task automatic write_reg(logic [1:0] idx, word_t value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx != REG_UNUSED)
      tracker.set_reg(reg_idx_t'(idx), value);
  endtask

  // Plaintext digit: mostly below p, with the edges and out-of-range values mixed in.
  function automatic word_t pick_message(word_t p);
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return p;
      2:       return p - 1;
      3:       return '0;
      4:       return '1;
      default: return (p > 1) ? word_t'($urandom_range(p - 1, 0)) : word_t'($urandom);
    endcase
  endfunction

  // Exponent: full-range random dominates; zero, all ones, p-1, short and single-bit ones too.
  function automatic word_t pick_exponent(word_t p);
    case ($urandom_range(11))
      0:       return '0;
      1:       return '1;
      2:       return p - 1;
      3:       return word_t'($urandom_range(255));
      4:       return word_t'(1) << $urandom_range(WORD_WIDTH - 1);
      default: return $urandom;
    endcase
  endfunction

  // One key setting followed by random requests in bursts. Short gaps raise start
  // while the core is busy; the occasional long one lets it sit idle first.
  task automatic run_phase(word_t p, word_t g, word_t k, int unsigned count);
    int unsigned gap;
    write_reg(REG_MODULUS, p);
    write_reg(REG_GENERATOR, g);
    write_reg(REG_PUBLIC_KEY, k);
    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(7) == 0) ? $urandom_range(5000, 2000) : $urandom_range(40, 1);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(12, 1);
      end
      send_request(pick_message(p), pick_exponent(p));
      burst_left--;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed: reset keys (p = 2^31-1, g = 2, k = 1) ---
    send_request('0, '0);                        // zero exponent, zero digit
    send_request('1, '1);                        // every bit set, digit above p
    send_request(32'd1, 32'd1);
    send_request(32'h7FFF_FFFE, 32'h7FFF_FFFE);  // p-1 both sides
    send_request(32'h7FFF_FFFF, 32'd1);          // digit equal to p
    send_request(32'h8000_0000, 32'd2);          // digit just above p
    send_request('1, '0);
    send_request('0, '1);
    send_request(32'd12345, 32'h8000_0000);      // single top exponent bit
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);

    // generator above p, key equal to p: both reduce before use
    write_reg(REG_GENERATOR, '1);
    write_reg(REG_PUBLIC_KEY, 32'h7FFF_FFFF);
    send_request(32'd7, '0);
    send_request(32'd7, 32'd5);

    // modulus of one: everything collapses to zero
    write_reg(REG_MODULUS, 32'd1);
    send_request('1, '1);
    send_request(32'd5, '0);

    // modulus of zero: no reduction defined, zero out
    write_reg(REG_MODULUS, '0);
    send_request('1, '1);
    send_request(32'd3, '0);

    // write to an unimplemented slot must leave the keys alone
    write_reg(REG_MODULUS, 32'hFFFF_FFFB);
    write_reg(REG_UNUSED, 32'd3);
    send_request(32'd9, 32'd10);

    // --- random: several key settings, extremes first ---
    run_phase(32'hFFFF_FFFB, 32'd2, $urandom_range(32'hFFFF_FFFF, 1), 120);
    run_phase(32'd3, 32'hFFFF_FFFF, 32'd2, 120);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 120);
    run_phase(32'h7FFF_FFFF, 32'd7, $urandom_range(32'hFFFF_FFFF, 1), 120);
    run_phase(32'd65521, 32'd17, $urandom_range(32'hFFFF_FFFF, 1), 120);
    for (int n = 0; n < 7; n++)
      run_phase($urandom_range(32'hFFFF_FFFF, 3), $urandom_range(32'hFFFF_FFFF, 1),
                $urandom_range(32'hFFFF_FFFF, 1), 120);

    // drain, then give any stray strobe time to appear
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending_ciphers.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
